FILE: rtl/core/pprt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pprt_pkg
// Shared types and constants of the partner run tracker: request and result
// payloads, the per-lane result record and the result queue sizing.
// ----------------------------------------------------------------------------
package pprt_pkg;

    localparam int IDX_W             = 10;
    localparam int RL_W              = 32;
    localparam int NUM_PARTICLES_DEF = 1024;
    localparam int COUNT_WIDTH_DEF   = 32;
    localparam int Q_DEPTH           = 4;
    localparam int QPTR_W            = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [IDX_W-1:0] particle_a;
        logic [IDX_W-1:0] particle_b;
    } pprt_event_t;

    typedef struct packed {
        logic [RL_W-1:0]  run_length;
        logic [IDX_W-1:0] owner_index;
        logic             last_of_event;
    } pprt_run_t;

    typedef struct packed {
        logic             emit;
        logic [RL_W-1:0]  run_length;
        logic [IDX_W-1:0] owner_index;
    } pprt_lane_res_t;

endpackage
`default_nettype wire

FILE: rtl/core/per_key_partner_run_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// per_key_partner_run_tracker
// Per-particle partner run tracker: counts consecutive pair events with the
// same partner and reports each completed run with its owner.
// ----------------------------------------------------------------------------
// Usage:
//   The event channel (event_valid / event_stall / event_data) takes one pair
//   request of particle_a and particle_b. The run channel (run_valid /
//   run_stall / run_data) returns zero to two completed runs per request, A
//   before B, with last_of_event set on the final one.
//   Results: a taken request is registered, both lanes update it in ST_EXEC
//   and its runs enter the result queue that drives the run channel. A new
//   request can be taken in ST_IDLE or ST_WRB, not in ST_EXEC. Both lanes
//   read their entries together from the two read ports of the table; its
//   single write port stores A's entry in ST_EXEC and B's in ST_WRB.
//   Reset: all table entries are cleared, one a cycle, with event_stall high.
//   Stall: up to four results wait in a queue; event_stall rises while
//   fewer than two queue slots are free, so nothing is dropped.
// ----------------------------------------------------------------------------
module per_key_partner_run_tracker #(
    parameter int NUM_PARTICLES = pprt_pkg::NUM_PARTICLES_DEF,
    parameter int COUNT_WIDTH   = pprt_pkg::COUNT_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  event_valid,
    output logic                  event_stall,
    input  pprt_pkg::pprt_event_t event_data,
    output logic                  run_valid,
    input  logic                  run_stall,
    output pprt_pkg::pprt_run_t   run_data
);
    import pprt_pkg::*;

    localparam int ADDR_W  = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
    localparam int ENTRY_W = IDX_W + COUNT_WIDTH;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_PARTICLES - 1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_WRB   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]    a_reg, b_reg;
    logic [ADDR_W-1:0]   a_addr_reg, b_addr_reg;
    logic [ENTRY_W-1:0]  rd_a_reg, rd_b_reg;
    logic                byp_valid_reg, byp_valid_next;
    logic [ADDR_W-1:0]   byp_addr_reg;
    logic [ENTRY_W-1:0]  byp_data_reg;
    logic                bw_en_reg, bw_en_next;
    logic [ENTRY_W-1:0]  bw_data_reg;

    logic [ENTRY_W-1:0]  mem [NUM_PARTICLES];

    logic                accept;
    logic                q_room;
    logic [IDX_W+ADDR_W-1:0] ev_a_wide, ev_b_wide;
    logic [ADDR_W-1:0]   ev_a_addr, ev_b_addr;
    logic                a_in, b_in;
    logic [ENTRY_W-1:0]  entry_a, entry_b_mem, entry_b;
    logic [IDX_W-1:0]    new_partner_a, new_partner_b;
    logic [COUNT_WIDTH-1:0] new_count_a, new_count_b;
    logic                wr_a, wr_b;
    pprt_lane_res_t      res_a, res_b;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0]  wr_data;

    assign accept      = event_valid && !event_stall;
    assign event_stall = !(((state_reg == ST_IDLE) || (state_reg == ST_WRB)) && q_room);

    assign ev_a_wide = {{ADDR_W{1'b0}}, event_data.particle_a};
    assign ev_b_wide = {{ADDR_W{1'b0}}, event_data.particle_b};
    assign ev_a_addr = ev_a_wide[ADDR_W-1:0];
    assign ev_b_addr = ev_b_wide[ADDR_W-1:0];

    assign a_in = (32'(a_reg) < 32'(NUM_PARTICLES));
    assign b_in = (32'(b_reg) < 32'(NUM_PARTICLES));

    assign entry_a = (byp_valid_reg && (byp_addr_reg == a_addr_reg)) ? byp_data_reg
                                                                      : rd_a_reg;
    assign entry_b_mem = (byp_valid_reg && (byp_addr_reg == b_addr_reg)) ? byp_data_reg
                                                                          : rd_b_reg;
    assign entry_b = (a_reg == b_reg) ? {new_partner_a, new_count_a} : entry_b_mem;

    pprt_lane #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane_a (
        .self_index    (a_reg),
        .in_range      (a_in),
        .partner       (b_reg),
        .entry_partner (entry_a[ENTRY_W-1 -: IDX_W]),
        .entry_count   (entry_a[COUNT_WIDTH-1:0]),
        .new_partner   (new_partner_a),
        .new_count     (new_count_a),
        .write_en      (wr_a),
        .result        (res_a)
    );

    pprt_lane #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane_b (
        .self_index    (b_reg),
        .in_range      (b_in),
        .partner       (a_reg),
        .entry_partner (entry_b[ENTRY_W-1 -: IDX_W]),
        .entry_count   (entry_b[COUNT_WIDTH-1:0]),
        .new_partner   (new_partner_b),
        .new_count     (new_count_b),
        .write_en      (wr_b),
        .result        (res_b)
    );

    pprt_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (state_reg == ST_EXEC),
        .res_a     (res_a),
        .res_b     (res_b),
        .room      (q_room),
        .run_valid (run_valid),
        .run_stall (run_stall),
        .run_data  (run_data)
    );

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = a_addr_reg;
        wr_data = {new_partner_a, new_count_a};
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
            end
            ST_EXEC:
            begin
                wr_en = wr_a;
            end
            ST_WRB:
            begin
                wr_en   = bw_en_reg;
                wr_addr = b_addr_reg;
                wr_data = bw_data_reg;
            end
            ST_IDLE:
            begin
                wr_en = 1'b0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        bw_en_next     = bw_en_reg;
        byp_valid_next = (state_reg == ST_WRB) && bw_en_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                bw_en_next = wr_b;
                state_next = ST_WRB;
            end
            ST_WRB:
            begin
                bw_en_next = 1'b0;
                state_next = accept ? ST_EXEC : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (accept)
        begin
            rd_a_reg <= mem[ev_a_addr];
            rd_b_reg <= mem[ev_b_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg      <= event_data.particle_a;
            b_reg      <= event_data.particle_b;
            a_addr_reg <= ev_a_addr;
            b_addr_reg <= ev_b_addr;
        end
        if (state_reg == ST_EXEC)
        begin
            bw_data_reg <= {new_partner_b, new_count_b};
        end
        byp_addr_reg <= b_addr_reg;
        byp_data_reg <= bw_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            byp_valid_reg <= 1'b0;
            bw_en_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            byp_valid_reg <= byp_valid_next;
            bw_en_reg     <= bw_en_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/pprt_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pprt_lane
// Update of one particle's table entry: extend a matching run with
// saturation, or close the old run and start a new one with the partner.
// ----------------------------------------------------------------------------
module pprt_lane #(
    parameter int COUNT_WIDTH = pprt_pkg::COUNT_WIDTH_DEF
) (
    input  logic [pprt_pkg::IDX_W-1:0] self_index,
    input  logic                       in_range,
    input  logic [pprt_pkg::IDX_W-1:0] partner,
    input  logic [pprt_pkg::IDX_W-1:0] entry_partner,
    input  logic [COUNT_WIDTH-1:0]     entry_count,
    output logic [pprt_pkg::IDX_W-1:0] new_partner,
    output logic [COUNT_WIDTH-1:0]     new_count,
    output logic                       write_en,
    output pprt_pkg::pprt_lane_res_t   result
);
    import pprt_pkg::*;

    logic                        match;
    logic                        sat;
    logic [COUNT_WIDTH+RL_W-1:0] cnt_wide;
    logic [COUNT_WIDTH-1:0]      cnt_hi;
    logic [RL_W-1:0]             rl;

    assign match    = (entry_partner == partner);
    assign sat      = &entry_count;
    assign cnt_wide = {{RL_W{1'b0}}, entry_count};
    assign cnt_hi   = cnt_wide[COUNT_WIDTH+RL_W-1:RL_W];
    assign rl       = (|cnt_hi) ? {RL_W{1'b1}} : cnt_wide[RL_W-1:0];

    always_comb
    begin
        new_partner        = partner;
        new_count          = COUNT_WIDTH'(1);
        write_en           = in_range;
        result.emit        = 1'b0;
        result.run_length  = rl;
        result.owner_index = self_index;
        if (match)
        begin
            new_count = sat ? entry_count : entry_count + COUNT_WIDTH'(1);
        end
        else
        begin
            result.emit = in_range && (entry_count != '0);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/pprt_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pprt_merge
// Combine the two lane results in event order, mark the last one, and hold
// them in a small result queue ahead of the output channel.
// ----------------------------------------------------------------------------
module pprt_merge (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  pprt_pkg::pprt_lane_res_t res_a,
    input  pprt_pkg::pprt_lane_res_t res_b,
    output logic                     room,
    output logic                     run_valid,
    input  logic                     run_stall,
    output pprt_pkg::pprt_run_t      run_data
);
    import pprt_pkg::*;

    pprt_run_t         q_mem [Q_DEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QPTR_W-1:0] tail_inc;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic [QPTR_W:0]   n_push;
    logic              pop;
    pprt_run_t         first, second;

    assign tail_inc  = tail_reg + QPTR_W'(1);
    assign run_valid = (cnt_reg != '0);
    assign run_data  = q_mem[head_reg];
    assign pop       = run_valid && !run_stall;
    assign room      = (cnt_reg <= (QPTR_W+1)'(Q_DEPTH - 2));

    always_comb
    begin
        first.run_length     = res_a.emit ? res_a.run_length : res_b.run_length;
        first.owner_index    = res_a.emit ? res_a.owner_index : res_b.owner_index;
        first.last_of_event  = !(res_a.emit && res_b.emit);
        second.run_length    = res_b.run_length;
        second.owner_index   = res_b.owner_index;
        second.last_of_event = 1'b1;
        n_push = push ? ((QPTR_W+1)'(res_a.emit) + (QPTR_W+1)'(res_b.emit)) : '0;
        cnt_next  = cnt_reg + n_push - (QPTR_W+1)'(pop);
        tail_next = tail_reg + n_push[QPTR_W-1:0];
        head_next = pop ? head_reg + QPTR_W'(1) : head_reg;
    end

    always_ff @(posedge clk)
    begin
        if (push && (res_a.emit || res_b.emit))
        begin
            q_mem[tail_reg] <= first;
        end
        if (push && res_a.emit && res_b.emit)
        begin
            q_mem[tail_inc] <= second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/pprt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pprt_checker
// Port-level checks of the partner run tracker, bound to the top level.
// ----------------------------------------------------------------------------
module pprt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                event_valid,
    input logic                event_stall,
    input logic                run_valid,
    input logic                run_stall,
    input pprt_pkg::pprt_run_t run_data
);
    import pprt_pkg::*;

    a_run_hold: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && run_stall |=> run_valid && $stable(run_data))
        else $error("run request changed while stalled");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid |-> (run_data.run_length != '0))
        else $error("run of zero length reported");

    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> event_stall)
        else $error("event taken during table clear");

    a_event_gap: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && !event_stall |=> event_stall)
        else $error("event taken in back-to-back cycles");

endmodule

bind per_key_partner_run_tracker pprt_checker u_pprt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .run_valid   (run_valid),
    .run_stall   (run_stall),
    .run_data    (run_data)
);
`default_nettype wire
